@@ design/packet_fragmenter_sequencer_core_assert.svh @@
// Assertion macros for the checker file of the fragmenter block.
`ifndef PACKET_FRAGMENTER_SEQUENCER_CORE_ASSERT_SVH
`define PACKET_FRAGMENTER_SEQUENCER_CORE_ASSERT_SVH

// Clocked assertion, ignored while reset is asserted.
`define PFS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define PFS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ design/pfs_pkg.sv @@
// Shared types, constants and codes of the packet fragmenter block.
`timescale 1ns / 1ps

package pfs_pkg;

	localparam int MAX_CHANNELS  = 16;
	localparam int MAX_FRAGMENTS = 64;
	localparam int CHAN_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

	localparam int CH_W    = 8;
	localparam int LEN_W   = 16;
	localparam int FLAGS_W = 2;
	localparam int SEQ_W   = 32;
	localparam int TOTAL_W = 7;
	localparam int INDEX_W = 6;
	localparam int ACT_W   = 5;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;

	localparam int IN_TDATA_W  = 24;
	localparam int OUT_TDATA_W = 192;
	localparam int OUT_TUSER_W = 3;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_PEER_CONNECTED   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_CHANNELS  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_FRAGMENT_PAYLOAD = 2'd2;

	localparam logic [ACT_W-1:0] ACTIVE_CHANNELS_RST  = 5'd1;
	localparam logic [LEN_W-1:0] FRAGMENT_PAYLOAD_RST = 16'd1024;

	// Send flag bits.
	localparam int FLAG_RELIABLE    = 0;
	localparam int FLAG_UNSEQUENCED = 1;

	typedef enum logic [1:0] {
		KIND_RELIABLE    = 2'd0,
		KIND_UNSEQUENCED = 2'd1,
		KIND_UNRELIABLE  = 2'd2,
		KIND_FRAGMENT    = 2'd3
	} kind_t;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECIDE = 5'b00010,
		ST_COUNT  = 5'b00100,
		ST_FRAG   = 5'b01000,
		ST_SEND   = 5'b10000
	} state_t;

	typedef struct packed {
		logic               status;
		kind_t              kind;
		logic [SEQ_W-1:0]   reliable_seq;
		logic [SEQ_W-1:0]   unreliable_seq;
		logic [SEQ_W-1:0]   unsequenced_group;
		logic [SEQ_W-1:0]   start_seq;
		logic [TOTAL_W-1:0] fragment_total;
		logic [INDEX_W-1:0] fragment_index;
		logic [LEN_W-1:0]   fragment_offset;
		logic [LEN_W-1:0]   fragment_length;
		logic [LEN_W-1:0]   total_length;
		logic               last;
	} result_t;

	// Outputs of the shared subtract / compare unit.
	typedef struct packed {
		logic [LEN_W-1:0] diff;
		logic             le;
		logic [LEN_W-1:0] min;
	} unit_res_t;

endpackage

@@ design/packet_fragmenter_sequencer_core.sv @@
// Top level of the packet fragmenter and sequencer.
`timescale 1ns / 1ps
//
// Send requests enter on the s_ stream: s_tdata holds channel and packet
// length, s_tuser the delivery flags. Results leave on the m_ stream, one
// request at a time; m_tlast marks the final result of a request.
// Configuration (peer_connected, active_channels, fragment_payload) is
// written through wr_en / wr_index / wr_data; the user must write it only
// while the block is idle, the block itself does not enforce this.
// A request that is rejected or fits in one command is decided in
// ST_DECIDE, which loads its result for ST_SEND. A fragmented request
// first runs one counting pass per fragment through the subtract unit
// that the builds also use (rejected past MAX_FRAGMENTS fragments), then
// each fragment is built in ST_FRAG and held in ST_SEND until accepted.
// s_tready is high only while idle: the next request is taken after the
// last result of the current one has been delivered.
// A stalled receiver holds the result register and the sequencer.
// Reset clears the channel and group counters and loads the register
// defaults (not connected, one channel, payload 1024).

module packet_fragmenter_sequencer_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// s_tdata: channel[7:0], packet_length[23:8]
	input  logic [pfs_pkg::IN_TDATA_W-1:0]      s_tdata,
	// s_tuser: send_flags[1:0]
	input  logic [pfs_pkg::FLAGS_W-1:0]         s_tuser,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// m_tdata: reliable_seq[31:0], unreliable_seq[63:32], unsequenced_group[95:64],
	// start_seq[127:96], fragment_total[134:128], fragment_index[140:135],
	// fragment_offset[156:141], fragment_length[172:157], total_length[188:173]
	output logic [pfs_pkg::OUT_TDATA_W-1:0]     m_tdata,
	// m_tuser: status[0], kind[2:1]
	output logic [pfs_pkg::OUT_TUSER_W-1:0]     m_tuser,
	output logic                                m_tlast,
	input  logic                                wr_en,
	input  logic [pfs_pkg::CFG_IDX_W-1:0]       wr_index,
	input  logic [pfs_pkg::CFG_DATA_W-1:0]      wr_data
);

	localparam logic [pfs_pkg::TOTAL_W-1:0] FRAG_MAX =
		pfs_pkg::TOTAL_W'(pfs_pkg::MAX_FRAGMENTS);
	localparam logic [pfs_pkg::CH_W-1:0] CH_LIMIT =
		pfs_pkg::CH_W'(pfs_pkg::MAX_CHANNELS);

	pfs_pkg::state_t state_q, state_d;

	// configuration
	logic                           peer_q;
	logic [pfs_pkg::ACT_W-1:0]      active_q;
	logic [pfs_pkg::LEN_W-1:0]      pay_q;

	// per-channel and peer counters
	logic [pfs_pkg::SEQ_W-1:0] rel_q  [pfs_pkg::MAX_CHANNELS];
	logic [pfs_pkg::SEQ_W-1:0] urel_q [pfs_pkg::MAX_CHANNELS];
	logic [pfs_pkg::SEQ_W-1:0] grp_q;

	// request and sequencing registers
	logic [pfs_pkg::CH_W-1:0]     ch_q;
	logic [pfs_pkg::LEN_W-1:0]    len_q;
	logic [pfs_pkg::FLAGS_W-1:0]  flags_q;
	logic [pfs_pkg::LEN_W-1:0]    rem_q;
	logic [pfs_pkg::TOTAL_W-1:0]  cnt_q;
	logic [pfs_pkg::TOTAL_W-1:0]  total_q;
	logic [pfs_pkg::INDEX_W-1:0]  idx_q;
	logic [pfs_pkg::LEN_W-1:0]    off_q;
	logic [pfs_pkg::SEQ_W-1:0]    start_q;
	pfs_pkg::result_t             res_q, res_d;

	logic                          res_load;
	logic                          rel_we, urel_we, grp_we;
	logic [pfs_pkg::CHAN_W-1:0]    ch_idx;
	logic [pfs_pkg::SEQ_W-1:0]     rel_cur, rel_inc, urel_inc, grp_inc, start_val;
	logic                          reject_req, frag_req, last_frag;
	logic [pfs_pkg::TOTAL_W-1:0]   cnt_inc;
	logic                          s_acc, m_acc;
	pfs_pkg::unit_res_t            unit;

	// One subtractor serves both the counting pass and the fragment builds.
	pfs_sub_unit u_sub (
		.a   (rem_q),
		.b   (pay_q),
		.res (unit)
	);

	assign s_tready = (state_q == pfs_pkg::ST_IDLE);
	assign m_tvalid = (state_q == pfs_pkg::ST_SEND);
	assign s_acc    = s_tvalid && s_tready;
	assign m_acc    = m_tvalid && m_tready;

	assign ch_idx   = ch_q[pfs_pkg::CHAN_W-1:0];
	assign rel_cur  = rel_q[ch_idx];
	assign rel_inc  = rel_cur + 32'd1;
	assign urel_inc = urel_q[ch_idx] + 32'd1;
	assign grp_inc  = grp_q + 32'd1;
	assign cnt_inc  = cnt_q + 7'd1;

	// Reject when disconnected or the channel is beyond the active or built range.
	assign reject_req = !peer_q || (ch_q >= {3'b000, active_q}) || (ch_q >= CH_LIMIT);
	assign frag_req   = len_q > pay_q;
	assign last_frag  = ({1'b0, idx_q} + 7'd1) == total_q;
	// The first fragment opens the run with its own sequence.
	assign start_val  = (idx_q == '0) ? rel_inc : start_q;

	function automatic pfs_pkg::result_t reject_res();
		pfs_pkg::result_t r;
		r        = '0;
		r.status = 1'b1;
		r.last   = 1'b1;
		return r;
	endfunction

	always_comb begin
		state_d  = state_q;
		res_d    = '0;
		res_load = 1'b0;
		rel_we   = 1'b0;
		urel_we  = 1'b0;
		grp_we   = 1'b0;
		case (state_q)
			pfs_pkg::ST_IDLE: begin
				if (s_acc) begin
					state_d = pfs_pkg::ST_DECIDE;
				end
			end
			pfs_pkg::ST_DECIDE: begin
				res_d.total_length    = len_q;
				res_d.fragment_length = len_q;
				res_d.last            = 1'b1;
				if (reject_req) begin
					res_d    = reject_res();
					res_load = 1'b1;
					state_d  = pfs_pkg::ST_SEND;
				end else if (frag_req) begin
					state_d = pfs_pkg::ST_COUNT;
				end else if (flags_q[pfs_pkg::FLAG_RELIABLE]) begin
					res_d.kind         = pfs_pkg::KIND_RELIABLE;
					res_d.reliable_seq = rel_inc;
					rel_we   = 1'b1;
					res_load = 1'b1;
					state_d  = pfs_pkg::ST_SEND;
				end else if (flags_q[pfs_pkg::FLAG_UNSEQUENCED]) begin
					res_d.kind              = pfs_pkg::KIND_UNSEQUENCED;
					res_d.unsequenced_group = grp_inc;
					grp_we   = 1'b1;
					res_load = 1'b1;
					state_d  = pfs_pkg::ST_SEND;
				end else begin
					res_d.kind           = pfs_pkg::KIND_UNRELIABLE;
					res_d.reliable_seq   = rel_cur;
					res_d.unreliable_seq = urel_inc;
					urel_we  = 1'b1;
					res_load = 1'b1;
					state_d  = pfs_pkg::ST_SEND;
				end
			end
			pfs_pkg::ST_COUNT: begin
				// one fragment per pass; give up once the fragment limit is hit
				if (unit.le) begin
					state_d = pfs_pkg::ST_FRAG;
				end else if (cnt_inc == FRAG_MAX) begin
					res_d    = reject_res();
					res_load = 1'b1;
					state_d  = pfs_pkg::ST_SEND;
				end
			end
			pfs_pkg::ST_FRAG: begin
				res_d.kind            = pfs_pkg::KIND_FRAGMENT;
				res_d.reliable_seq    = rel_inc;
				res_d.start_seq       = start_val;
				res_d.fragment_total  = total_q;
				res_d.fragment_index  = idx_q;
				res_d.fragment_offset = off_q;
				res_d.fragment_length = unit.min;
				res_d.total_length    = len_q;
				res_d.last            = last_frag;
				rel_we   = 1'b1;
				res_load = 1'b1;
				state_d  = pfs_pkg::ST_SEND;
			end
			pfs_pkg::ST_SEND: begin
				if (m_acc) begin
					state_d = res_q.last ? pfs_pkg::ST_IDLE : pfs_pkg::ST_FRAG;
				end
			end
			default: begin
				state_d = pfs_pkg::ST_IDLE;
			end
		endcase
	end

	// Control state, configuration and counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= pfs_pkg::ST_IDLE;
			peer_q   <= 1'b0;
			active_q <= pfs_pkg::ACTIVE_CHANNELS_RST;
			pay_q    <= pfs_pkg::FRAGMENT_PAYLOAD_RST;
			grp_q    <= '0;
			for (int i = 0; i < pfs_pkg::MAX_CHANNELS; i++) begin
				rel_q[i]  <= '0;
				urel_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (wr_en) begin
				case (wr_index)
					pfs_pkg::REG_PEER_CONNECTED:   peer_q   <= wr_data[0];
					pfs_pkg::REG_ACTIVE_CHANNELS:  active_q <= wr_data[pfs_pkg::ACT_W-1:0];
					pfs_pkg::REG_FRAGMENT_PAYLOAD: pay_q    <= wr_data;
					default: ;
				endcase
			end
			if (rel_we) begin
				rel_q[ch_idx] <= rel_inc;
			end
			if (urel_we) begin
				urel_q[ch_idx] <= urel_inc;
			end
			if (grp_we) begin
				grp_q <= grp_inc;
			end
		end
	end

	// Request payload and fragment sequencing registers.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			ch_q    <= s_tdata[pfs_pkg::CH_W-1:0];
			len_q   <= s_tdata[pfs_pkg::CH_W +: pfs_pkg::LEN_W];
			flags_q <= s_tuser;
		end
		case (state_q)
			pfs_pkg::ST_DECIDE: begin
				rem_q <= len_q;
				cnt_q <= '0;
			end
			pfs_pkg::ST_COUNT: begin
				cnt_q <= cnt_inc;
				if (unit.le) begin
					// count known: rewind for the build pass
					total_q <= cnt_inc;
					rem_q   <= len_q;
					idx_q   <= '0;
					off_q   <= '0;
				end else begin
					rem_q <= unit.diff;
				end
			end
			pfs_pkg::ST_FRAG: begin
				rem_q   <= unit.diff;
				start_q <= start_val;
			end
			pfs_pkg::ST_SEND: begin
				if (m_acc && !res_q.last) begin
					idx_q <= idx_q + 6'd1;
					off_q <= off_q + pay_q;
				end
			end
			default: ;
		endcase
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign m_tdata = {3'b000,
		res_q.total_length, res_q.fragment_length, res_q.fragment_offset,
		res_q.fragment_index, res_q.fragment_total, res_q.start_seq,
		res_q.unsequenced_group, res_q.unreliable_seq, res_q.reliable_seq};
	assign m_tuser = {res_q.kind, res_q.status};
	assign m_tlast = res_q.last;

endmodule

@@ design/pfs_sub_unit.sv @@
// Shared subtract / compare unit: remainder minus payload, compare and minimum.
`timescale 1ns / 1ps

module pfs_sub_unit (
	input  logic [pfs_pkg::LEN_W-1:0] a,
	input  logic [pfs_pkg::LEN_W-1:0] b,
	output pfs_pkg::unit_res_t        res
);

	logic [pfs_pkg::LEN_W:0] wide;

	assign wide = {1'b0, a} - {1'b0, b};

	always_comb begin
		res.diff = wide[pfs_pkg::LEN_W-1:0];
		// borrow means a < b
		res.le   = wide[pfs_pkg::LEN_W] || (wide[pfs_pkg::LEN_W-1:0] == '0);
		res.min  = wide[pfs_pkg::LEN_W] ? a : b;
	end

endmodule

@@ design/pfs_checker.sv @@
// Port-level checker for the fragmenter top level, with its bind.
`timescale 1ns / 1ps
`include "packet_fragmenter_sequencer_core_assert.svh"

module pfs_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_tvalid,
	input logic                            s_tready,
	input logic                            m_tvalid,
	input logic                            m_tready,
	input logic [pfs_pkg::OUT_TDATA_W-1:0] m_tdata,
	input logic [pfs_pkg::OUT_TUSER_W-1:0] m_tuser,
	input logic                            m_tlast
);

	`PFS_ASSERT_RST(a_hold_stalled, clk, arst_n, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "stalled result changed")
	`PFS_ASSERT_RST(a_one_request, clk, arst_n, !(s_tready && m_tvalid), "request taken while a result is pending")
	`PFS_ASSERT_RST(a_busy_after_accept, clk, arst_n, s_tvalid && s_tready |=> !s_tready && !m_tvalid, "no busy cycle after request")
	`PFS_ASSERT_RST(a_reject_last, clk, arst_n, m_tvalid && m_tuser[0] |-> m_tlast && (m_tuser[2:1] == pfs_pkg::KIND_RELIABLE), "rejected result malformed")
	`PFS_ASSERT_RST(a_single_last, clk, arst_n, m_tvalid && (m_tuser[2:1] != pfs_pkg::KIND_FRAGMENT) |-> m_tlast, "unfragmented result without last")

endmodule

bind packet_fragmenter_sequencer_core pfs_checker u_pfs_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
